[sv/axis_units_to_steps_scaler_macros.svh]
// Assertion macros shared by the scaler checker.
`ifndef AXIS_UNITS_TO_STEPS_SCALER_MACROS_SVH
`define AXIS_UNITS_TO_STEPS_SCALER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AUSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AUSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Check that is also evaluated during reset.
`define AUSC_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/ausc_pkg.sv]
// Shared types, constants and status codes of the axis unit scaler.
package ausc_pkg;

    localparam int NUM_AXES  = 3;
    localparam int REG_AXES  = 3;
    localparam int RATIO_W   = 31;
    localparam int VALUE_W   = 32;
    localparam int PROD_W    = VALUE_W + RATIO_W;
    localparam int NUM_REGS  = 2 * REG_AXES;
    localparam int CFG_IDX_W = 3;

    localparam logic [RATIO_W-1:0] PULSES_RESET = RATIO_W'(3200);
    localparam logic [RATIO_W-1:0] TRAVEL_RESET = RATIO_W'(5000);

    // Request kinds
    localparam logic REQ_UM_TO_STEPS = 1'b0;
    localparam logic REQ_STEPS_TO_UM = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_AXIS = 2'd1;
    localparam logic [1:0] ST_ZDIV = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // Item travelling down the divider stages
    typedef struct packed {
        logic               valid;
        logic [1:0]         code;   // error status decided up front
        logic               neg;
        logic               ovf;    // quotient does not fit in 32 bits
        logic [RATIO_W-1:0] div;
        logic [RATIO_W-1:0] rem;    // partial remainder
        logic [VALUE_W-1:0] low;    // dividend bits, quotient shifts in
    } t_div_item;

endpackage

[sv/ausc_front.sv]
// Front end: ratio selection, magnitude, 63-bit product and rounding bias.
module ausc_front
    import ausc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  logic                         i_valid,
    input  logic                         i_req_type,
    input  logic [1:0]                   i_axis_sel,
    input  logic [VALUE_W-1:0]           i_in_value,
    input  logic [REG_AXES*RATIO_W-1:0]  i_pulses,
    input  logic [REG_AXES*RATIO_W-1:0]  i_travel,
    output t_div_item                    o_item
);

    logic               r_valid0;
    logic [1:0]         r_code0;
    logic               r_neg0;
    logic [VALUE_W-1:0] r_mag0;
    logic [RATIO_W-1:0] r_mul0;
    logic [RATIO_W-1:0] r_div0;
    t_div_item          r_item;

    logic [RATIO_W-1:0] n_mul0;
    logic [RATIO_W-1:0] n_div0;
    logic [1:0]         n_code0;
    logic [PROD_W-1:0]  n_num;
    t_div_item          n_item;

    // Stage 0: pick ratio pair for axis and direction, check errors
    always_comb begin
        n_mul0  = '0;
        n_div0  = '0;
        n_code0 = ST_OK;
        if (32'(i_axis_sel) >= 32'(NUM_AXES) || 32'(i_axis_sel) >= 32'(REG_AXES)) begin
            n_code0 = ST_AXIS;
        end else begin
            if (i_req_type == REQ_UM_TO_STEPS) begin
                n_mul0 = i_pulses[i_axis_sel*RATIO_W +: RATIO_W];
                n_div0 = i_travel[i_axis_sel*RATIO_W +: RATIO_W];
            end else begin
                n_mul0 = i_travel[i_axis_sel*RATIO_W +: RATIO_W];
                n_div0 = i_pulses[i_axis_sel*RATIO_W +: RATIO_W];
            end
            if (n_div0 == '0) begin
                n_code0 = ST_ZDIV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (i_ce) begin
            r_valid0 <= i_valid;
        end
        if (i_ce) begin
            r_code0 <= n_code0;
            r_neg0  <= i_in_value[VALUE_W-1];
            r_mag0  <= i_in_value[VALUE_W-1] ? (~i_in_value + 1'b1) : i_in_value;
            r_mul0  <= n_mul0;
            r_div0  <= n_div0;
        end
    end

    // Stage 1: product plus half divisor, overflow when top part >= divisor
    always_comb begin
        n_num        = PROD_W'(r_mag0) * PROD_W'(r_mul0) + PROD_W'(r_div0 >> 1);
        n_item.valid = r_valid0;
        n_item.code  = r_code0;
        n_item.neg   = r_neg0;
        n_item.div   = r_div0;
        n_item.ovf   = (n_num[PROD_W-1:VALUE_W] >= r_div0);
        n_item.rem   = n_num[PROD_W-1:VALUE_W];
        n_item.low   = n_num[VALUE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_ce) begin
            r_item.valid <= n_item.valid;
        end
        if (i_ce) begin
            r_item.code <= n_item.code;
            r_item.neg  <= n_item.neg;
            r_item.ovf  <= n_item.ovf;
            r_item.div  <= n_item.div;
            r_item.rem  <= n_item.rem;
            r_item.low  <= n_item.low;
        end
    end

    assign o_item = r_item;

endmodule

[sv/ausc_div_stage.sv]
// One restoring division step: produces one quotient bit per stage.
module ausc_div_stage
    import ausc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_ce,
    input  t_div_item i_item,
    output t_div_item o_item
);

    t_div_item            r_item;
    t_div_item            n_item;
    logic [RATIO_W:0]     n_trial;
    logic                 n_qbit;

    // Shift next dividend bit into remainder, subtract when it fits
    always_comb begin
        n_trial = {i_item.rem, i_item.low[VALUE_W-1]};
        n_qbit  = (n_trial >= {1'b0, i_item.div});
        n_item  = i_item;
        n_item.low = {i_item.low[VALUE_W-2:0], n_qbit};
        if (n_qbit) begin
            n_item.rem = RATIO_W'(n_trial - {1'b0, i_item.div});
        end else begin
            n_item.rem = n_trial[RATIO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_ce) begin
            r_item.valid <= n_item.valid;
        end
        if (i_ce) begin
            r_item.code <= n_item.code;
            r_item.neg  <= n_item.neg;
            r_item.ovf  <= n_item.ovf;
            r_item.div  <= n_item.div;
            r_item.rem  <= n_item.rem;
            r_item.low  <= n_item.low;
        end
    end

    assign o_item = r_item;

endmodule

[sv/axis_units_to_steps_scaler.sv]
// Axis unit scaler: converts a signed distance between micrometres and motor
// steps as value * ratio_a / ratio_b, rounded half away from zero, with
// saturation to the int32 range. One transaction is accepted every cycle
// unless the pipeline stalls; each result passes two front stages (ratio
// selection and the 32x31 multiply), one stage per quotient bit in a 32-stage
// divider, and one output stage. The whole pipeline advances together, so it
// holds when a finished result is not taken. Invalid axis and zero divisor
// give 0 with a status code in tuser. Ratio registers are written through
// the cfg channel, which is always ready, and must be changed only while idle.
module axis_units_to_steps_scaler
    import ausc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [31:0]           i_s_axis_tdata,   // [31:0] in_value
    input  logic [7:0]            i_s_axis_tuser,   // [0] req_type, [2:1] axis_sel
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [31:0]           o_m_axis_tdata,   // [31:0] out_value
    output logic [7:0]            o_m_axis_tuser,   // [1:0] status
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [RATIO_W-1:0]    i_cfg_data
);

    localparam int DIV_STAGES = VALUE_W;

    logic [REG_AXES*RATIO_W-1:0] r_pulses;
    logic [REG_AXES*RATIO_W-1:0] r_travel;
    logic                        ce;
    t_div_item                   stage [0:DIV_STAGES];

    logic                        r_out_valid;
    logic [VALUE_W-1:0]          r_out_value;
    logic [1:0]                  r_out_status;
    logic [VALUE_W-1:0]          n_out_value;
    logic [1:0]                  n_out_status;
    t_div_item                   last;

    // Ratio registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < REG_AXES; a++) begin
                r_pulses[a*RATIO_W +: RATIO_W] <= PULSES_RESET;
                r_travel[a*RATIO_W +: RATIO_W] <= TRAVEL_RESET;
            end
        end else if (i_cfg_valid) begin
            for (int a = 0; a < REG_AXES; a++) begin
                if (32'(i_cfg_index) == a) begin
                    r_pulses[a*RATIO_W +: RATIO_W] <= i_cfg_data;
                end
                if (32'(i_cfg_index) == a + REG_AXES) begin
                    r_travel[a*RATIO_W +: RATIO_W] <= i_cfg_data;
                end
            end
        end
    end

    // Pipeline moves whenever the output slot is free or being taken
    assign ce              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    ausc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (ce),
        .i_valid    (i_s_axis_tvalid),
        .i_req_type (i_s_axis_tuser[0]),
        .i_axis_sel (i_s_axis_tuser[2:1]),
        .i_in_value (i_s_axis_tdata),
        .i_pulses   (r_pulses),
        .i_travel   (r_travel),
        .o_item     (stage[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        ausc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_item  (stage[g]),
            .o_item  (stage[g+1])
        );
    end

    // Sign restore and saturation
    assign last = stage[DIV_STAGES];
    always_comb begin
        n_out_value  = last.low;
        n_out_status = ST_OK;
        if (last.code != ST_OK) begin
            n_out_value  = '0;
            n_out_status = last.code;
        end else if (!last.neg) begin
            if (last.ovf || last.low > POS_LIMIT) begin
                n_out_value  = POS_LIMIT;
                n_out_status = ST_SAT;
            end
        end else begin
            if (last.ovf || last.low > NEG_LIMIT) begin
                n_out_value  = NEG_LIMIT;
                n_out_status = ST_SAT;
            end else begin
                n_out_value = ~last.low + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= last.valid;
        end
        if (ce) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = {6'b0, r_out_status};

endmodule

[sv/ausc_checker.sv]
// Port-level checker for the axis unit scaler, bound to the top level.
`include "axis_units_to_steps_scaler_macros.svh"

module ausc_checker
    import ausc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [7:0]  o_m_axis_tuser
);

    // error results carry a zero value
    `AUSC_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser[1:0] == ST_AXIS || o_m_axis_tuser[1:0] == ST_ZDIV), o_m_axis_tdata == '0)
    // saturated results sit on a limit
    `AUSC_ASSERT_NOW(a_sat_limit, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1:0] == ST_SAT, o_m_axis_tdata == POS_LIMIT || o_m_axis_tdata == NEG_LIMIT)
    // a stalled result holds
    `AUSC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    // no result right after reset
    `AUSC_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind axis_units_to_steps_scaler ausc_checker u_ausc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
